[src/sddf_pkg.sv]
// ============================================================================
// sddf_pkg: shared types and constants for the speed digit display formatter
// Slot codes, register indexes, reciprocal constants for the decimal split
// and the word types passed between the split and layout stages.
// ============================================================================
package sddf_pkg;

    // Display geometry
    localparam int SLOT_COUNT = 7;
    localparam int SPEED_W    = 20;

    // Slot codes (0-9 are plain digits)
    localparam logic [3:0] CODE_BLANK = 4'd10;
    localparam logic [3:0] CODE_POINT = 4'd11;

    // Alignment modes
    localparam logic [1:0] ALIGN_OFF   = 2'd0;
    localparam logic [1:0] ALIGN_RIGHT = 2'd1;
    localparam logic [1:0] ALIGN_LEFT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALIGN = 2'd0;
    localparam logic [1:0] CFG_DEC   = 2'd1;
    localparam logic [1:0] CFG_CAP   = 2'd2;

    // Largest fraction digit count that is shown
    localparam logic [2:0] DEC_MAX = 3'd3;

    // Reset values of the configuration registers
    localparam logic [1:0]         ALIGN_RST = ALIGN_RIGHT;
    localparam logic [2:0]         DEC_RST   = 3'd0;
    localparam logic [SPEED_W-1:0] CAP_RST   = 20'hFFFFF;

    // Reciprocals: floor(v / 10^k) = (v * M) >> S, exact for v < 2^20
    localparam int PROD_W = 41;
    localparam logic [20:0] RECIP_1E1 = 21'd838861;
    localparam logic [20:0] RECIP_1E2 = 21'd671089;
    localparam logic [20:0] RECIP_1E3 = 21'd1073742;
    localparam logic [20:0] RECIP_1E4 = 21'd858994;
    localparam logic [20:0] RECIP_1E5 = 21'd687195;

    // Quotients of the clamped speed by 10, 100, ... 100000
    typedef struct packed {
        logic [3:0]  v_lo;   // low bits of the speed itself
        logic [16:0] q1;     // v / 10
        logic [13:0] q2;     // v / 100
        logic [10:0] q3;     // v / 1000
        logic [6:0]  q4;     // v / 10000
        logic [3:0]  q5;     // v / 100000 (0..10)
    } t_quot;

    // Slot codes, slot zero in the lowest nibble
    typedef logic [SLOT_COUNT-1:0][3:0] t_slots;

endpackage

[src/sddf_split.sv]
// ============================================================================
// sddf_split: decimal quotients of the clamped speed
// Five constant reciprocal multiplies in parallel, one per decimal place.
// ============================================================================
module sddf_split (
    input  logic [sddf_pkg::SPEED_W-1:0] i_v,
    output sddf_pkg::t_quot              o_quot
);
    import sddf_pkg::*;

    logic [PROD_W-1:0] w_p1;
    logic [PROD_W-1:0] w_p2;
    logic [PROD_W-1:0] w_p3;
    logic [PROD_W-1:0] w_p4;
    logic [PROD_W-1:0] w_p5;

    // Multiply by scaled reciprocals
    assign w_p1 = PROD_W'(i_v) * PROD_W'(RECIP_1E1);
    assign w_p2 = PROD_W'(i_v) * PROD_W'(RECIP_1E2);
    assign w_p3 = PROD_W'(i_v) * PROD_W'(RECIP_1E3);
    assign w_p4 = PROD_W'(i_v) * PROD_W'(RECIP_1E4);
    assign w_p5 = PROD_W'(i_v) * PROD_W'(RECIP_1E5);

    // Shift out the scale
    assign o_quot.v_lo = i_v[3:0];
    assign o_quot.q1   = w_p1[39:23];
    assign o_quot.q2   = w_p2[39:26];
    assign o_quot.q3   = w_p3[40:30];
    assign o_quot.q4   = w_p4[39:33];
    assign o_quot.q5   = w_p5[39:36];

endmodule

[src/sddf_layout.sv]
// ============================================================================
// sddf_layout: digit extraction and slot placement
// Recovers each digit from neighboring quotients, suppresses leading zeros
// and places the digit string left or right aligned into the slots.
// ============================================================================
module sddf_layout (
    input  sddf_pkg::t_quot  i_quot,
    input  logic [1:0]       i_align,
    input  logic [2:0]       i_dec,
    output sddf_pkg::t_slots o_slots
);
    import sddf_pkg::*;

    logic [SLOT_COUNT-1:0][3:0] w_full;
    logic [3:0] w_lead_len;
    logic [3:0] w_len;
    logic [3:0] w_skip;
    logic [3:0] w_start;
    logic       w_on;

    // digit = q(k) - 10 * q(k+1), only the low nibble matters
    always_comb begin
        w_full[0] = (i_quot.q5 == 4'd10) ? 4'd0 : i_quot.q5;
        w_full[1] = 4'(i_quot.q4[3:0] - 4'(i_quot.q5 * 4'd10));
        w_full[2] = 4'(i_quot.q3[3:0] - 4'(i_quot.q4[3:0] * 4'd10));
        w_full[3] = CODE_POINT;
        w_full[4] = 4'(i_quot.q2[3:0] - 4'(i_quot.q3[3:0] * 4'd10));
        w_full[5] = 4'(i_quot.q1[3:0] - 4'(i_quot.q2[3:0] * 4'd10));
        w_full[6] = 4'(i_quot.v_lo    - 4'(i_quot.q1[3:0] * 4'd10));
    end

    // String length and where it starts
    always_comb begin
        priority if (i_quot.q5 != 4'd0) begin
            w_lead_len = 4'd3;
        end else if (i_quot.q4 != 7'd0) begin
            w_lead_len = 4'd2;
        end else begin
            w_lead_len = 4'd1;
        end
        w_skip  = 4'd3 - w_lead_len;
        w_len   = (i_dec == 3'd0) ? w_lead_len : 4'(w_lead_len + {1'b0, i_dec} + 4'd1);
        w_start = (i_align == ALIGN_RIGHT) ? 4'(4'(SLOT_COUNT) - w_len) : 4'd0;
        w_on    = (i_align == ALIGN_RIGHT || i_align == ALIGN_LEFT) && (i_dec <= DEC_MAX);
    end

    // Per-slot select from the full digit string
    always_comb begin
        logic [3:0] pos;
        logic [3:0] idx;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            pos = 4'(4'(i) - w_start);
            idx = 4'(pos + w_skip);
            if (w_on && (4'(i) >= w_start) && (pos < w_len)) begin
                o_slots[i] = w_full[idx[2:0]];
            end else begin
                o_slots[i] = CODE_BLANK;
            end
        end
    end

endmodule

[src/speed_digit_display_formatter.sv]
// Path: an accepted input word passes the input, quotient and output registers.
// Throughput: one word per cycle; the three-register pipeline stalls as a
// whole only while the output register holds a word that is not taken.
// Reset (i_rst_n low, synchronous): pipeline empties, alignment right,
// zero decimals, cap at full scale.
// ============================================================================
// speed_digit_display_formatter: speed to seven-slot digit display codes
// Clamps the speed, splits it into decimal digits and lays them out into
// display slot codes (digit, blank, point).
// ============================================================================
module speed_digit_display_formatter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream: tdata[19:0] speed_milli, [23:20] zero
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,
    // Result stream: tdata[3:0] slot_zero, [7:4] slot_one, [11:8] slot_two,
    // [15:12] slot_three, [19:16] slot_four, [23:20] slot_five,
    // [27:24] slot_six, [31:28] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import sddf_pkg::*;

    // Configuration registers
    logic [1:0]         r_align;
    logic [2:0]         r_dec;
    logic [SPEED_W-1:0] r_cap;

    // Pipeline registers
    logic               r_v_vld;
    logic [SPEED_W-1:0] r_v;
    logic               r_q_vld;
    t_quot              r_quot;
    logic               r_out_vld;
    t_slots             r_slots;

    logic [SPEED_W-1:0] n_v;
    t_quot              n_quot;
    t_slots             n_slots;
    logic               w_adv;

    // Configuration writes, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= ALIGN_RST;
            r_dec   <= DEC_RST;
            r_cap   <= CAP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ALIGN: r_align <= i_cfg_data[1:0];
                CFG_DEC:   r_dec   <= i_cfg_data[2:0];
                CFG_CAP:   r_cap   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Pipeline moves whenever the output word is empty or being taken
    assign w_adv      = !r_out_vld || i_m_tready;
    assign o_s_tready = w_adv;

    // Clamp on the way into the input register
    assign n_v = (i_s_tdata[SPEED_W-1:0] > r_cap) ? r_cap : i_s_tdata[SPEED_W-1:0];

    sddf_split u_split (
        .i_v    (r_v),
        .o_quot (n_quot)
    );

    sddf_layout u_layout (
        .i_quot  (r_quot),
        .i_align (r_align),
        .i_dec   (r_dec),
        .o_slots (n_slots)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_vld   <= 1'b0;
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_v_vld   <= i_s_tvalid;
            r_q_vld   <= r_v_vld;
            r_out_vld <= r_q_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v     <= n_v;
            r_quot  <= n_quot;
            r_slots <= n_slots;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'd0, r_slots};

    // A word in the input stage moves into the quotient stage on advance
    a_v_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_v_vld) |=> r_q_vld)
        else $error("input stage word lost");

    // A quotient word moves into the output register on advance
    a_q_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_q_vld) |=> r_out_vld)
        else $error("quotient stage word lost");

    // Input stalls only behind a full output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // Reciprocal quotients agree: hundreds present implies tens present
    a_quot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_vld && r_quot.q5 != 4'd0) |-> (r_quot.q4 != 7'd0))
        else $error("inconsistent decimal quotients");

endmodule
